>>> sv/pdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PID differential duty controller.
// Used by pdd_corr_pipe and pid_differential_duty_core.
package pdd_pkg;

    localparam int GAIN_W   = 32;
    localparam int ERR_W    = 16;
    localparam int SUM_W    = 32;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int DUTY_W   = 16;
    localparam int CORR_W   = 64;
    localparam int FRAC_SH  = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY  = 2'd3;

    typedef struct packed {
        logic signed [ERR_W-1:0] error_sample;
        logic                    clear_history;
    } t_pdd_in;

    typedef struct packed {
        logic [DUTY_W-1:0] first_motor_duty;
        logic [DUTY_W-1:0] second_motor_duty;
    } t_pdd_out;

    typedef struct packed {
        logic                     valid;
        logic signed [ERR_W-1:0]  error_sample;
        logic signed [SUM_W-1:0]  error_sum;
        logic signed [DIFF_W-1:0] error_diff;
    } t_pdd_term;

endpackage

>>> sv/pdd_corr_pipe.sv
`timescale 1ns / 1ps
// Two-stage correction pipeline: three gain products, then their sum.
// Depends on pdd_pkg for the term struct and widths.
module pdd_corr_pipe
    import pdd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [GAIN_W-1:0] i_gain_prop,
    input  logic signed [GAIN_W-1:0] i_gain_integ,
    input  logic signed [GAIN_W-1:0] i_gain_deriv,
    input  t_pdd_term                i_term,
    output logic                     o_ready,
    output logic                     o_corr_valid,
    output logic signed [CORR_W-1:0] o_corr,
    input  logic                     i_down_ready
);

    localparam int PP_W = GAIN_W + ERR_W;
    localparam int PI_W = GAIN_W + SUM_W;
    localparam int PD_W = GAIN_W + DIFF_W;

    logic signed [PP_W-1:0]   n_pp, r_pp;
    logic signed [PI_W-1:0]   n_pi, r_pi;
    logic signed [PD_W-1:0]   n_pd, r_pd;
    logic signed [CORR_W-1:0] n_corr, r_corr;
    logic                     r_prod_valid, r_corr_valid;
    logic                     w_prod_ready, w_corr_ready;

    assign n_pp = i_gain_prop  * i_term.error_sample;
    assign n_pi = i_gain_integ * i_term.error_sum;
    assign n_pd = i_gain_deriv * i_term.error_diff;

    assign n_corr = CORR_W'(r_pp) + CORR_W'(r_pi) + CORR_W'(r_pd);

    assign w_corr_ready = !r_corr_valid || i_down_ready;
    assign w_prod_ready = !r_prod_valid || w_corr_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_corr_valid <= 1'b0;
        end else begin
            if (w_prod_ready) begin
                r_prod_valid <= i_term.valid;
            end
            if (w_corr_ready) begin
                r_corr_valid <= r_prod_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prod_ready && i_term.valid) begin
            r_pp <= n_pp;
            r_pi <= n_pi;
            r_pd <= n_pd;
        end
        if (w_corr_ready && r_prod_valid) begin
            r_corr <= n_corr;
        end
    end

    assign o_ready      = w_prod_ready;
    assign o_corr_valid = r_corr_valid;
    assign o_corr       = r_corr;

endmodule

>>> sv/pid_differential_duty_core.sv
`timescale 1ns / 1ps
// Top level of the PID differential duty controller.
// Depends on pdd_pkg and pdd_corr_pipe.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one error
//   sample per request. A request with clear_history set zeroes the error sum
//   and previous error and yields no result; any other request yields one
//   result on the output channel (o_out_valid / i_out_stall / o_out_data)
//   with the first and second motor duties in Q1.15.
//   Gains and base duty are written through i_cfg_we / i_cfg_index /
//   i_cfg_data, one register per cycle, while no request is in flight.
//   A result passes the term register (loaded at acceptance), then the product
//   register, correction sum register and duty output register. Throughput:
//   one request per cycle while the receiver does not stall; the 32x32
//   integral product and the 64-bit correction sum each fill one pipeline
//   stage.
//   Reset clears the gain and base duty registers, the error sum and the
//   previous error to zero and empties the pipeline. When the receiver
//   stalls, each stage holds until the next frees up; bubbles still fill,
//   and o_in_stall rises only when the term register cannot move on.
module pid_differential_duty_core
    import pdd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pdd_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_pdd_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam int WIDE_W = CORR_W + 1;
    localparam logic signed [WIDE_W-1:0] FULL_Q24 = WIDE_W'(1) <<< (DUTY_W + FRAC_SH - 1);

    function automatic logic [DUTY_W-1:0] to_duty(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v < 0) begin
            c = '0;
        end else if (v > FULL_Q24) begin
            c = FULL_Q24;
        end
        return c[FRAC_SH +: DUTY_W];
    endfunction

    logic signed [GAIN_W-1:0] r_gain_prop, r_gain_integ, r_gain_deriv;
    logic [DUTY_W-1:0]        r_base_duty;

    logic signed [SUM_W-1:0]  r_error_sum;
    logic signed [ERR_W-1:0]  r_last_error;
    t_pdd_term                r_term;

    logic                     w_accept;
    logic                     w_term_ready;
    logic signed [SUM_W:0]    n_sum_wide;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DIFF_W-1:0] n_diff;

    logic                     w_corr_ready;
    logic                     w_corr_valid;
    logic signed [CORR_W-1:0] w_corr;
    logic                     w_corr_pos;
    logic signed [WIDE_W-1:0] w_base, n_first, n_second;
    logic                     w_out_ready;

    logic                     r_out_valid;
    t_pdd_out                 r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= '0;
            r_gain_integ <= '0;
            r_gain_deriv <= '0;
            r_base_duty  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                CFG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                CFG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                CFG_BASE_DUTY:  r_base_duty  <= i_cfg_data[DUTY_W-1:0];
            endcase
        end
    end

    // saturating error sum and difference
    assign n_sum_wide = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(i_in_data.error_sample);
    always_comb begin
        n_sum = n_sum_wide[SUM_W-1:0];
        if (n_sum_wide[SUM_W] != n_sum_wide[SUM_W-1]) begin
            n_sum = n_sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end
    assign n_diff = DIFF_W'(i_in_data.error_sample) - DIFF_W'(r_last_error);

    assign w_term_ready = !r_term.valid || w_corr_ready;
    assign o_in_stall   = !w_term_ready;
    assign w_accept     = i_in_valid && w_term_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_term.valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (i_in_data.clear_history) begin
                    r_error_sum  <= '0;
                    r_last_error <= '0;
                end else begin
                    r_error_sum  <= n_sum;
                    r_last_error <= i_in_data.error_sample;
                end
            end
            if (w_term_ready) begin
                r_term.valid <= w_accept && !i_in_data.clear_history;
            end
        end
        if (w_accept && !i_in_data.clear_history) begin
            r_term.error_sample <= i_in_data.error_sample;
            r_term.error_sum    <= n_sum;
            r_term.error_diff   <= n_diff;
        end
    end

    pdd_corr_pipe u_corr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gain_prop  (r_gain_prop),
        .i_gain_integ (r_gain_integ),
        .i_gain_deriv (r_gain_deriv),
        .i_term       (r_term),
        .o_ready      (w_corr_ready),
        .o_corr_valid (w_corr_valid),
        .o_corr       (w_corr),
        .i_down_ready (w_out_ready)
    );

    // steer the correction to one motor, clamp both duties
    assign w_corr_pos = !w_corr[CORR_W-1] && (w_corr != '0);
    assign w_base     = WIDE_W'({r_base_duty, {FRAC_SH{1'b0}}});
    assign n_first    = w_corr_pos ? w_base + WIDE_W'(w_corr) : w_base;
    assign n_second   = w_corr_pos ? w_base : w_base - WIDE_W'(w_corr);

    assign w_out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_corr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_corr_valid) begin
            r_out_data.first_motor_duty  <= to_duty(n_first);
            r_out_data.second_motor_duty <= to_duty(n_second);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_differential_duty_core: drives error samples and
// register writes, predicts both motor duties and compares every result.
// Depends on pdd_pkg and the RTL under sv/.
module testbench;
    import pdd_pkg::*;

    localparam int     RST_CYCLES  = 11;
    localparam int     DRAIN_GAP   = 8;
    localparam int     STALL_LIMIT = 2000;
    localparam int     MAX_REPORTS = 64;
    localparam longint SUM_MAX     = 64'sd2147483647;
    localparam longint SUM_MIN     = -64'sd2147483648;
    localparam longint FULL_Q24    = 64'sd16777216;
    localparam logic signed [ERR_W-1:0]  ERR_MAX  = 16'sh7FFF;
    localparam logic signed [ERR_W-1:0]  ERR_MIN  = 16'sh8000;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 32'sh7FFFFFFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 32'sh80000000;

    class duty_scoreboard;
        logic signed [GAIN_W-1:0] gain_p    = '0;
        logic signed [GAIN_W-1:0] gain_i    = '0;
        logic signed [GAIN_W-1:0] gain_d    = '0;
        logic [DUTY_W-1:0]        base_duty = '0;
        logic signed [SUM_W-1:0]  err_sum   = '0;
        logic signed [ERR_W-1:0]  prev_err  = '0;
        t_pdd_out                 duty_expected[$];
        int                       mismatches = 0;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                CFG_GAIN_PROP:  gain_p = data;
                CFG_GAIN_INTEG: gain_i = data;
                CFG_GAIN_DERIV: gain_d = data;
                CFG_BASE_DUTY:  base_duty = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DUTY_W-1:0] duty_of(longint q);
            if (q < 0)
                q = 0;
            else if (q > FULL_Q24)
                q = FULL_Q24;
            return DUTY_W'(q >>> FRAC_SH);
        endfunction

        function void note_request(t_pdd_in req);
            longint   e, s, corr, base_q, first_q, second_q;
            t_pdd_out duty;
            if (req.clear_history) begin
                err_sum  = '0;
                prev_err = '0;
                return;
            end
            e = longint'(req.error_sample);
            s = longint'(err_sum) + e;
            if (s > SUM_MAX)
                s = SUM_MAX;
            else if (s < SUM_MIN)
                s = SUM_MIN;
            err_sum = SUM_W'(s);
            corr = longint'(gain_p) * e + longint'(gain_i) * s
                 + longint'(gain_d) * (e - longint'(prev_err));
            prev_err = req.error_sample;
            base_q = longint'(base_duty) <<< FRAC_SH;
            if (corr > 0) begin
                first_q  = base_q + corr;
                second_q = base_q;
            end else begin
                first_q  = base_q;
                second_q = base_q - corr;
            end
            duty.first_motor_duty  = duty_of(first_q);
            duty.second_motor_duty = duty_of(second_q);
            duty_expected.push_back(duty);
        endfunction

        function void report(string what, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_duty(t_pdd_out got);
            t_pdd_out want;
            if (duty_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual %0d / %0d",
                             $time, got.first_motor_duty, got.second_motor_duty);
                return;
            end
            want = duty_expected.pop_front();
            if (got.first_motor_duty !== want.first_motor_duty)
                report("first_motor_duty", want.first_motor_duty, got.first_motor_duty);
            if (got.second_motor_duty !== want.second_motor_duty)
                report("second_motor_duty", want.second_motor_duty, got.second_motor_duty);
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_pdd_in              in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_pdd_out             out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_GAIN_PROP;
    logic [GAIN_W-1:0]    cfg_data  = '0;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int quiet_cycles = 0;

    duty_scoreboard duties = new;

    always #2 clk = ~clk;

    pid_differential_duty_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            duties.check_duty(out_data);
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_request(t_pdd_in req);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        duties.note_request(req);
    endtask

    task automatic send_error(logic signed [ERR_W-1:0] e, logic clr = 1'b0);
        t_pdd_in req;
        req.error_sample  = e;
        req.clear_history = clr;
        send_request(req);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (duties.duty_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        duties.set_register(idx, data);
    endtask

    task automatic apply_settings(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                                  logic [GAIN_W-1:0] gd, logic [DUTY_W-1:0] base);
        write_register(CFG_GAIN_PROP, gp);
        write_register(CFG_GAIN_INTEG, gi);
        write_register(CFG_GAIN_DERIV, gd);
        write_register(CFG_BASE_DUTY, {{(GAIN_W-DUTY_W){1'b0}}, base});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(int span);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return GAIN_W'($urandom_range(0, 2 * span)) - GAIN_W'(span);
            2: return GAIN_W'($urandom_range(0, 128)) - 32'd64;
            default: return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
        endcase
    endfunction

    function automatic t_pdd_in make_request();
        t_pdd_in req;
        int      pick;
        pick = $urandom_range(0, 99);
        req.clear_history = (pick < 5);
        if (pick < 15)
            req.error_sample = ERR_W'($urandom);
        else if (pick < 25)
            req.error_sample = $urandom_range(0, 1) ? ERR_MAX : ERR_MIN;
        else if (pick < 60)
            req.error_sample = ERR_W'($urandom);
        else
            req.error_sample = ERR_W'($urandom_range(0, 600)) - 16'd300;
        return req;
    endfunction

    initial begin
        logic [DUTY_W-1:0] base;
        in_idle_pct  = 7;
        out_idle_pct = 69;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_error(16'sd1234);
        send_error(ERR_MIN);
        drain();

        apply_settings(32'sd512, 32'sd16, -32'sd256, 16'd16384);
        send_error(16'sd0);
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        send_error(ERR_MAX);
        send_error(16'sd1);
        send_error(-16'sd1);
        send_error(ERR_MAX, 1'b1);
        send_error(16'sd100);
        send_error(-16'sd100);
        send_error(ERR_MIN, 1'b1);
        send_error(16'sd0);
        send_error(16'sd12345);
        drain();

        apply_settings(GAIN_MAX, GAIN_MIN, GAIN_MAX, 16'hFFFF);
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        send_error(16'sd0);
        send_error(16'sd1);
        drain();

        apply_settings(GAIN_MIN, GAIN_MAX, GAIN_MIN, 16'd0);
        send_error(ERR_MIN);
        send_error(ERR_MAX);
        send_error(-16'sd1);
        send_error(16'sd0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            case (phase / 3)
                0: begin in_idle_pct = 7;  out_idle_pct = 69; end
                1: begin in_idle_pct = 69; out_idle_pct = 7;  end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            if (phase == 2) begin
                apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, 16'd32768);
            end else if (phase == 5) begin
                apply_settings(GAIN_MIN, GAIN_MIN, GAIN_MIN, 16'd0);
            end else begin
                if (phase == 8)
                    base = 16'hFFFF;
                else if ($urandom_range(0, 7) == 0)
                    base = DUTY_W'($urandom_range(32769, 65535));
                else
                    base = DUTY_W'($urandom_range(0, 32768));
                apply_settings(pick_gain(4096), pick_gain(16), pick_gain(4096), base);
            end
            repeat (128) send_request(make_request());
            drain();
        end

        if (duties.duty_expected.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     duties.duty_expected.size());
        if (duties.mismatches == 0 && duties.duty_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
sv/pdd_pkg.sv
sv/pdd_corr_pipe.sv
sv/pid_differential_duty_core.sv
bench/testbench.sv
